@@ sv/gdad_pkg.sv @@
package gdad_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 16;
    localparam int ADD_W    = 16;
    // Running day count: add_days + day + a full year still fits.
    localparam int REM_W    = 17;
    // Year modulo 400 tracker.
    localparam int Y400_W   = 9;
    localparam int MOD_STEPS_W = 3;

    localparam logic [Y400_W-1:0]  CYCLE_YEARS = 9'd400;
    localparam logic [Y400_W-1:0]  CYCLE_LAST  = 9'd399;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 16'hFFFF;
    localparam logic [MOD_STEPS_W-1:0] MOD_TOP_SHIFT = 3'd7;

    localparam logic [DAY_W-1:0] MONTH_LEN [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               overflow;
    } date_t;

    typedef struct packed {
        logic [REM_W-1:0] a;
        logic [REM_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [REM_W:0] sum;
        logic           neg;
        logic           zero;
    } alu_rsp_t;

    // Leap test from the year modulo 400; the low two bits equal year mod 4.
    function automatic logic is_leap(input logic [Y400_W-1:0] y400);
        logic century;
        century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
        return (y400 == '0) || ((y400[1:0] == 2'b00) && !century);
    endfunction

    // Months outside 1..12 have no days.
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        if (m >= MONTH_JAN && m <= MONTH_DEC) begin
            if (m == MONTH_FEB && leap)
                len = 5'd29;
            else
                len = MONTH_LEN[m - MONTH_JAN];
        end
        return len;
    endfunction

endpackage

@@ sv/gregorian_date_add_days.sv @@
// Sequence: after the accept edge the year is reduced modulo 400, add_days + start_day is
// formed, the months before start_month are added, then the walk goes forward a month at
// a time until the remaining days fit, and the result is loaded into the output register.
// Throughput: one request at a time; the next request is taken once the result sits in
// the output register. Reset: rst_n is asynchronous, active low, idles all and clears out_valid.
module gregorian_date_add_days (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gdad_pkg::DAY_W-1:0]    start_day,
    input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
    input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
    input  logic [gdad_pkg::ADD_W-1:0]    add_days,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gdad_pkg::DAY_W-1:0]    end_day,
    output logic [gdad_pkg::MONTH_W-1:0]  end_month,
    output logic [gdad_pkg::YEAR_W-1:0]   end_year,
    output logic                          year_overflow
);
    import gdad_pkg::*;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    date_t    result;
    logic     done_valid;
    logic     done_take;
    logic     out_valid_reg;
    date_t    out_reg;

    // The sequencer owns every working register and drives the single adder.
    gdad_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_day   (start_day),
        .start_month (start_month),
        .start_year  (start_year),
        .add_days    (add_days),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp),
        .done_valid  (done_valid),
        .done_take   (done_take),
        .result      (result)
    );

    // Shared add/subtract unit used for the year reduction, add_days + start_day, the month sum and the walk.
    gdad_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // The output register frees the sequencer as soon as the result is copied here,
    // so a new request can start while this one waits for the consumer.
    assign done_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_take)
        begin
            out_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_take)
            out_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign end_day       = out_reg.day;
    assign end_month     = out_reg.month;
    assign end_year      = out_reg.year;
    assign year_overflow = out_reg.overflow;

endmodule

@@ sv/gdad_alu.sv @@
module gdad_alu (
    input  gdad_pkg::alu_req_t req,
    output gdad_pkg::alu_rsp_t rsp
);
    import gdad_pkg::*;

    logic [REM_W:0] b_ext;

    // One adder serves both add and subtract; a set top bit is a negative difference.
    assign b_ext   = req.sub ? ~{1'b0, req.b} : {1'b0, req.b};
    assign rsp.sum = {1'b0, req.a} + b_ext + {{REM_W{1'b0}}, req.sub};
    assign rsp.neg = rsp.sum[REM_W];
    assign rsp.zero = (rsp.sum == '0);

endmodule

@@ sv/gdad_seq.sv @@
module gdad_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gdad_pkg::DAY_W-1:0]    start_day,
    input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
    input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
    input  logic [gdad_pkg::ADD_W-1:0]    add_days,
    output gdad_pkg::alu_req_t            alu_req,
    input  gdad_pkg::alu_rsp_t            alu_rsp,
    output logic                          done_valid,
    input  logic                          done_take,
    output gdad_pkg::date_t               result
);
    import gdad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_INIT,
        S_SUM,
        S_WALK,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [REM_W-1:0]    remain_reg, remain_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [Y400_W-1:0]   y400_reg, y400_next;
    logic [MONTH_W-1:0]  month_in_reg, month_in_next;
    logic [MONTH_W-1:0]  m_reg, m_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [ADD_W-1:0]    add_reg, add_next;
    logic [MOD_STEPS_W-1:0] k_reg, k_next;
    logic                ovf_reg, ovf_next;

    logic                leap;
    logic [DAY_W-1:0]    len;
    logic [REM_W-1:0]    mod_step;

    assign leap     = is_leap(y400_reg);
    assign len      = month_length(m_reg, leap);
    assign mod_step = {{(REM_W-Y400_W){1'b0}}, CYCLE_YEARS} << k_reg;

    always_comb
    begin
        alu_req = '{a: remain_reg, b: '0, sub: 1'b0};
        case (state_reg)
            S_MOD:   alu_req = '{a: remain_reg, b: mod_step, sub: 1'b1};
            S_INIT:  alu_req = '{a: {{(REM_W-DAY_W){1'b0}}, day_reg},
                                 b: {{(REM_W-ADD_W){1'b0}}, add_reg}, sub: 1'b0};
            S_SUM:   alu_req = '{a: remain_reg, b: {{(REM_W-DAY_W){1'b0}}, len},
                                 sub: 1'b0};
            S_WALK:  alu_req = '{a: remain_reg, b: {{(REM_W-DAY_W){1'b0}}, len},
                                 sub: 1'b1};
            default: alu_req = '{a: remain_reg, b: '0, sub: 1'b0};
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        remain_next   = remain_reg;
        year_next     = year_reg;
        y400_next     = y400_reg;
        month_in_next = month_in_reg;
        m_next        = m_reg;
        day_next      = day_reg;
        add_next      = add_reg;
        k_next        = k_reg;
        ovf_next      = ovf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    remain_next   = {{(REM_W-YEAR_W){1'b0}}, start_year};
                    year_next     = start_year;
                    month_in_next = start_month;
                    day_next      = start_day;
                    add_next      = add_days;
                    k_next        = MOD_TOP_SHIFT;
                    ovf_next      = 1'b0;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                // Restoring reduction of the year by 400 shifted down one bit a cycle.
                if (!alu_rsp.neg)
                    remain_next = alu_rsp.sum[REM_W-1:0];
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    y400_next  = alu_rsp.neg ? remain_reg[Y400_W-1:0]
                                             : alu_rsp.sum[Y400_W-1:0];
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                remain_next = alu_rsp.sum[REM_W-1:0];
                m_next      = MONTH_JAN;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                if (m_reg < month_in_reg)
                begin
                    remain_next = alu_rsp.sum[REM_W-1:0];
                    m_next      = m_reg + 1'b1;
                end
                else
                begin
                    m_next     = MONTH_JAN;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (alu_rsp.neg || alu_rsp.zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    remain_next = alu_rsp.sum[REM_W-1:0];
                    if (m_reg == MONTH_DEC)
                    begin
                        m_next = MONTH_JAN;
                        if (year_reg == YEAR_MAX)
                        begin
                            year_next = '0;
                            y400_next = '0;
                            ovf_next  = 1'b1;
                        end
                        else
                        begin
                            year_next = year_reg + 1'b1;
                            y400_next = (y400_reg == CYCLE_LAST) ? '0 : y400_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        m_next = m_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (done_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            remain_reg   <= '0;
            year_reg     <= '0;
            y400_reg     <= '0;
            month_in_reg <= '0;
            m_reg        <= MONTH_JAN;
            day_reg      <= '0;
            add_reg      <= '0;
            k_reg        <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            remain_reg   <= remain_next;
            year_reg     <= year_next;
            y400_reg     <= y400_next;
            month_in_reg <= month_in_next;
            m_reg        <= m_next;
            day_reg      <= day_next;
            add_reg      <= add_next;
            k_reg        <= k_next;
            ovf_reg      <= ovf_next;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign done_valid      = (state_reg == S_DONE);
    assign result.day      = remain_reg[DAY_W-1:0];
    assign result.month    = m_reg;
    assign result.year     = year_reg;
    assign result.overflow = ovf_reg;

    // The month walk never leaves the calendar months.
    a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (m_reg >= MONTH_JAN && m_reg <= MONTH_DEC))
        else $error("month out of range during walk");

    // A finished walk leaves no more than one month of days.
    a_done_day: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (remain_reg <= 17'd31))
        else $error("remaining days exceed a month");

    // The year-in-cycle tracker stays below 400 once computed.
    a_y400_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM || state_reg == S_WALK) |-> (y400_reg < CYCLE_YEARS))
        else $error("year modulo 400 out of range");

    // An accepted request starts the year reduction at the top shift.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MOD && k_reg == MOD_TOP_SHIFT))
        else $error("request did not start the sequence");

endmodule

@@ test/gregorian_date_add_days_test.sv @@
`timescale 1ns / 100ps

// Keeps the dates still owed by the block, in request order, and checks each
// returned date against the oldest of them.
class date_scoreboard;

    gdad_pkg::date_t owed[$];
    int unsigned     errors;

    function new();
        errors = 0;
    endfunction

    // Gregorian leap rule on the full 16-bit year.
    function bit leap_year(input logic [15:0] y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function int unsigned days_in_month(input logic [3:0] m, input logic [15:0] y);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
            4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
            gdad_pkg::MONTH_FEB:                        return leap_year(y) ? 29 : 28;
            default:                                    return 0;
        endcase
    endfunction

    // Forms the ordinal day in the start year, adds the count, then walks
    // forward a month at a time, carrying into the next year after December.
    function gdad_pkg::date_t add_to_date(input logic [4:0] d, input logic [3:0] m,
                                          input logic [15:0] y, input logic [15:0] n);
        gdad_pkg::date_t r;
        int unsigned     remain;
        logic [3:0]      mon;
        logic [15:0]     yr;
        logic            wrapped;
        remain  = n + d;
        yr      = y;
        wrapped = 1'b0;
        for (int k = 1; k < m; k++)
            remain += days_in_month(k[3:0], yr);
        mon = gdad_pkg::MONTH_JAN;
        while (remain > days_in_month(mon, yr)) begin
            remain -= days_in_month(mon, yr);
            if (mon == gdad_pkg::MONTH_DEC) begin
                mon = gdad_pkg::MONTH_JAN;
                if (yr == gdad_pkg::YEAR_MAX)
                    wrapped = 1'b1;
                yr = yr + 16'd1;
            end
            else begin
                mon = mon + 4'd1;
            end
        end
        r.day      = remain[4:0];
        r.month    = mon;
        r.year     = yr;
        r.overflow = wrapped;
        return r;
    endfunction

    function void note_request(input logic [4:0] d, input logic [3:0] m,
                               input logic [15:0] y, input logic [15:0] n);
        owed.push_back(add_to_date(d, m, y, n));
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(input gdad_pkg::date_t got);
        gdad_pkg::date_t want;
        if (owed.size() == 0) begin
            $display("%0t: unexpected result %0d-%0d-%0d ovf %0d, expected none",
                     $time, got.year, got.month, got.day, got.overflow);
            errors++;
        end
        else begin
            want = owed.pop_front();
            compare_field("end_day", want.day, got.day);
            compare_field("end_month", want.month, got.month);
            compare_field("end_year", want.year, got.year);
            compare_field("year_overflow", want.overflow, got.overflow);
        end
    endfunction

    function int unsigned owed_count();
        return owed.size();
    endfunction

endclass

module gregorian_date_add_days_test;

    import gdad_pkg::*;

    // A request walks month by month through its count, and the receiver may
    // add a long hold-off on top, so the watchdog allows far more than both
    // without any request or result moving.
    localparam int unsigned STALL_LIMIT    = 20000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned RANDOM_COUNT   = 250;
    localparam int unsigned IDLE_PERCENT   = 21;
    localparam int unsigned SETTLE_CYCLES  = 50;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [DAY_W-1:0]    start_day;
    logic [MONTH_W-1:0]  start_month;
    logic [YEAR_W-1:0]   start_year;
    logic [ADD_W-1:0]    add_days;
    logic                out_valid;
    logic                out_ready;
    logic [DAY_W-1:0]    end_day;
    logic [MONTH_W-1:0]  end_month;
    logic [YEAR_W-1:0]   end_year;
    logic                year_overflow;

    date_scoreboard sb;

    // When pacing_on is low, neither side idles at random.
    bit          pacing_on;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit          hold_request;
    // Set by the receiver once that hold-off has been started.
    bit          hold_taken;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    gregorian_date_add_days i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_day     (start_day),
        .start_month   (start_month),
        .start_year    (start_year),
        .add_days      (add_days),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .end_day       (end_day),
        .end_month     (end_month),
        .end_year      (end_year),
        .year_overflow (year_overflow)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Presents one request. It is entered at a falling edge and returns at
    // the falling edge after the request was accepted. in_valid is left high
    // so that back-to-back requests do not drop it; a random idle cycle
    // lowers it first.
    task automatic send_request(input logic [4:0] d, input logic [3:0] m,
                                input logic [15:0] y, input logic [15:0] n);
        while (pacing_on && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        start_day   = d;
        start_month = m;
        start_year  = y;
        add_days    = n;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(d, m, y, n);
        @(negedge clk);
    endtask

    // Holds the sender off until every date owed by the block has come back.
    task automatic wait_for_results();
        in_valid = 1'b0;
        while (sb.owed_count() != 0)
            @(negedge clk);
    endtask

    // Receiver: ready changes only at the falling edge. A long hold-off is
    // counted here, independent of the sender, so the block fills up and
    // has to stall its input.
    initial
    begin
        out_ready  = 1'b0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                out_ready = 1'b0;
                hold_left--;
            end
            else begin
                out_ready = !(pacing_on && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // Results are taken at the rising edge on which valid and ready are both high.
    always @(posedge clk)
    begin
        gdad_pkg::date_t got;
        if (rst_n && out_valid && out_ready) begin
            got.day      = end_day;
            got.month    = end_month;
            got.year     = end_year;
            got.overflow = year_overflow;
            sb.check_result(got);
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles",
                         $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned sel;
        logic [4:0]  d;
        logic [3:0]  m;
        logic [15:0] y;
        logic [15:0] n;

        sb           = new();
        pacing_on    = 1'b1;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        start_day    = '0;
        start_month  = '0;
        start_year   = '0;
        add_days     = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed requests: field extremes and the calendar corner cases.
        send_request(5'd1, 4'd1, 16'd2024, 16'd0);        // nothing to add
        send_request(5'd0, 4'd1, 16'd2000, 16'd0);        // start day zero gives day zero
        send_request(5'd0, 4'd0, 16'd0, 16'd0);           // all fields zero
        send_request(5'd28, 4'd2, 16'd2000, 16'd1);       // leap by the 400 rule
        send_request(5'd28, 4'd2, 16'd1900, 16'd1);       // century, not leap
        send_request(5'd28, 4'd2, 16'd2100, 16'd1);
        send_request(5'd28, 4'd2, 16'd2024, 16'd1);       // ordinary leap year
        send_request(5'd28, 4'd2, 16'd2023, 16'd1);       // ordinary common year
        send_request(5'd31, 4'd2, 16'd2023, 16'd0);       // day past month end spills over
        send_request(5'd31, 4'd11, 16'd2023, 16'd0);
        send_request(5'd15, 4'd0, 16'd2020, 16'd10);      // month zero: ordinal is the day
        send_request(5'd10, 4'd13, 16'd2020, 16'd5);      // month 13: whole year before it
        send_request(5'd5, 4'd15, 16'd2021, 16'd0);
        send_request(5'd31, 4'd12, 16'd2023, 16'd1);      // plain year carry
        send_request(5'd31, 4'd12, 16'd65535, 16'd1);     // year wraps to zero
        send_request(5'd1, 4'd1, 16'd65535, 16'd0);
        send_request(5'd31, 4'd12, 16'd65534, 16'd366);
        send_request(5'd1, 4'd1, 16'd0, 16'd65535);       // year zero is a leap year
        send_request(5'd31, 4'd12, 16'd2023, 16'd65535);
        send_request(5'd31, 4'd15, 16'd65535, 16'd65535); // every input bit set
        send_request(5'd1, 4'd3, 16'd65400, 16'd65535);   // long walk through the wrap

        // Random requests. Most add a small count so the month walk stays short;
        // about a quarter cover the full count range and exercise long walks.
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            // The receiver goes quiet for a long stretch while requests keep coming.
            if (i == 60)
                hold_request = 1'b1;
            // A long stretch where neither side idles.
            if (i == 100)
                pacing_on = 1'b0;
            if (i == 140)
                pacing_on = 1'b1;
            // Let the block drain completely once before carrying on.
            if (i == 170)
                wait_for_results();

            sel = $urandom_range(99);
            d = (sel < 85) ? 5'($urandom_range(1, 31)) : 5'($urandom_range(0, 31));
            sel = $urandom_range(99);
            m = (sel < 88) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(0, 15));
            sel = $urandom_range(99);
            if (sel < 50)
                y = 16'($urandom_range(1800, 2500));
            else if (sel < 80)
                y = 16'($urandom_range(0, 65535));
            else if (sel < 90)
                y = 16'($urandom_range(65400, 65535));
            else
                y = 16'($urandom_range(0, 500));
            sel = $urandom_range(99);
            n = (sel < 75) ? 16'($urandom_range(0, 800)) : 16'($urandom_range(0, 65535));
            send_request(d, m, y, n);
        end

        wait_for_results();
        // Give the block time to show any result it should not produce.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.owed_count() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
